@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL top level of the response field extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/gre_pkg.sv @@
// Types, constants and helper functions of the response field extractor.
`timescale 1ns / 1ps

package gre_pkg;

  localparam int unsigned PrefixLen = 10;
  localparam int unsigned CntW      = 8;

  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharPlus  = 8'h2B;

  localparam logic [CntW-1:0] CntMax       = '1;
  localparam logic [CntW-1:0] MaxLenReset  = 8'd31;
  localparam logic [CntW-1:0] FieldIdxReset = 8'd0;

  // Configuration register indexes.
  typedef enum logic {
    CFG_FIELD_INDEX = 1'b0,
    CFG_MAX_LEN     = 1'b1
  } cfg_reg_e;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_SEEK  = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_FIELD = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  // One accepted input beat held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
    logic       last;
  } in_beat_t;

  // One result item on its way to the output register.
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] field_byte;
    logic [7:0] field_length;
    logic       found;
  } result_t;

  // Characters of the "+CGNSINF: " prefix.
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h2B; // +
      4'd1:    ch = 8'h43; // C
      4'd2:    ch = 8'h47; // G
      4'd3:    ch = 8'h4E; // N
      4'd4:    ch = 8'h53; // S
      4'd5:    ch = 8'h49; // I
      4'd6:    ch = 8'h4E; // N
      4'd7:    ch = 8'h46; // F
      4'd8:    ch = 8'h3A; // :
      4'd9:    ch = 8'h20; // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? v : v + 1'b1;
  endfunction

endpackage

@@ sv/gnss_response_field_extractor.sv @@
// Top level of the GNSS response field extractor.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid_i/tready_o       tdata: rx_byte; tlast: end_of_response
//  m_axis    out  m_axis_tvalid_o/tready_i       tdata: field_byte, field_length, found
//                                                tuser: kind
//  cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// Each byte beat passes an input register, the combinational parser logic and a result
// register, and any result that it causes reaches m_axis from that result register.
// One byte is taken every cycle while the result register is free or being emptied.
// A stall on m_axis holds the input register, which then deasserts s_axis_tready_o.
// Reset clears the parser to prefix search, field_index to 0 and max_field_len to 31.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gnss_response_field_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] field_byte, [15:8] field_length, [16] found
  output logic        m_axis_tuser_o,   // [0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  gre_pkg::in_beat_t beat;
  gre_pkg::result_t  res;
  gre_pkg::phase_e   phase;
  logic              out_free;
  logic              advance;

  assign cfg_ready_o = 1'b1;
  assign advance     = beat.valid && out_free;

  gre_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tlast_i  (s_axis_tlast_i),
    .advance_i  (advance),
    .beat_o     (beat)
  );

  gre_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (gre_pkg::cfg_reg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .beat_i      (beat),
    .advance_i   (advance),
    .res_o       (res),
    .phase_o     (phase)
  );

  gre_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (res),
    .advance_i  (advance),
    .free_o     (out_free),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

  // The input side never stalls while the result register is empty.
  `ASSERT_IMPL(a_ready_when_out_empty, !m_axis_tvalid_o, s_axis_tready_o)
  // A data byte is only produced while inside the selected field.
  `ASSERT_IMPL(a_data_only_in_field, advance && res.valid && res.kind == gre_pkg::KIND_DATA,
               phase == gre_pkg::PH_FIELD)
  // The last beat of a response returns the parser to prefix search.
  `ASSERT_NEXT(a_restart_after_last, advance && beat.last, phase == gre_pkg::PH_SEEK)

endmodule

@@ sv/gre_in_reg.sv @@
// Input register: holds one accepted byte beat until the parser consumes it.
`timescale 1ns / 1ps

module gre_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [7:0]        s_tdata_i,
  input  logic              s_tlast_i,
  input  logic              advance_i,
  output gre_pkg::in_beat_t beat_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  assign s_tready_o = !valid_q || advance_i;
  assign take       = s_tvalid_i && s_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= s_tdata_i;
      last_q <= s_tlast_i;
    end
  end

  assign beat_o = '{valid: valid_q, rx_byte: byte_q, last: last_q};

endmodule

@@ sv/gre_core.sv @@
// Parser core: configuration registers, prefix/comma/field state and result logic.
`timescale 1ns / 1ps

module gre_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  gre_pkg::cfg_reg_e cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  gre_pkg::in_beat_t beat_i,
  input  logic              advance_i,
  output gre_pkg::result_t  res_o,
  output gre_pkg::phase_e   phase_o
);

  logic [7:0] field_index_q, max_len_q;

  gre_pkg::phase_e phase_q, phase_d;
  logic [3:0]      matched_q, matched_d;
  logic [7:0]      commas_q, commas_d;
  logic [7:0]      taken_q, taken_d;

  logic [7:0] c;
  logic       is_term;

  assign c       = beat_i.rx_byte;
  assign is_term = (c == gre_pkg::CharComma) || (c == gre_pkg::CharCr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_index_q <= gre_pkg::FieldIdxReset;
      max_len_q     <= gre_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gre_pkg::CFG_FIELD_INDEX: field_index_q <= cfg_data_i;
        gre_pkg::CFG_MAX_LEN:     max_len_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic data_ok;
    logic [7:0] commas_inc;
    phase_d   = phase_q;
    matched_d = matched_q;
    commas_d  = commas_q;
    taken_d   = taken_q;
    data_ok   = 1'b0;
    res_o     = '{valid: 1'b0, kind: gre_pkg::KIND_DATA, field_byte: 8'd0,
                  field_length: 8'd0, found: 1'b0};
    commas_inc = gre_pkg::sat_inc(commas_q);

    case (phase_q)
      gre_pkg::PH_SEEK: begin
        if (c == gre_pkg::prefix_char(matched_q)) begin
          matched_d = matched_q + 4'd1;
        end else begin
          matched_d = (c == gre_pkg::CharPlus) ? 4'd1 : 4'd0;
        end
        if (matched_d == 4'(gre_pkg::PrefixLen)) begin
          matched_d = 4'd0;
          commas_d  = 8'd0;
          taken_d   = 8'd0;
          phase_d   = (field_index_q == 8'd0) ? gre_pkg::PH_FIELD : gre_pkg::PH_SKIP;
        end
      end
      gre_pkg::PH_SKIP: begin
        if (c == gre_pkg::CharComma) begin
          commas_d = commas_inc;
          if (commas_inc >= field_index_q) begin
            phase_d = gre_pkg::PH_FIELD;
          end
        end
      end
      gre_pkg::PH_FIELD: begin
        if (is_term) begin
          res_o = '{valid: 1'b1, kind: gre_pkg::KIND_DONE, field_byte: 8'd0,
                    field_length: taken_q, found: 1'b1};
          phase_d = gre_pkg::PH_DONE;
        end else if (taken_q < max_len_q) begin
          data_ok = 1'b1;
        end
      end
      gre_pkg::PH_DONE: ;
      default: ;
    endcase

    if (beat_i.last) begin
      // The end of a response closes it with a not-found result unless it
      // has already been closed.
      if (!res_o.valid && phase_d != gre_pkg::PH_DONE) begin
        res_o = '{valid: 1'b1, kind: gre_pkg::KIND_DONE, field_byte: 8'd0,
                  field_length: 8'd0, found: 1'b0};
      end
      phase_d   = gre_pkg::PH_SEEK;
      matched_d = 4'd0;
      commas_d  = 8'd0;
      taken_d   = 8'd0;
    end else if (data_ok) begin
      res_o = '{valid: 1'b1, kind: gre_pkg::KIND_DATA, field_byte: c,
                field_length: 8'd0, found: 1'b0};
      taken_d = gre_pkg::sat_inc(taken_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= gre_pkg::PH_SEEK;
      matched_q <= 4'd0;
      commas_q  <= 8'd0;
      taken_q   <= 8'd0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      matched_q <= matched_d;
      commas_q  <= commas_d;
      taken_q   <= taken_d;
    end
  end

  assign phase_o = phase_q;

endmodule

@@ sv/gre_out_reg.sv @@
// Result register: holds one result beat until the downstream side takes it.
`timescale 1ns / 1ps

module gre_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gre_pkg::result_t res_i,
  input  logic             advance_i,
  output logic             free_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [23:0]      m_tdata_o,
  output logic             m_tuser_o
);

  logic             valid_q, valid_d;
  gre_pkg::result_t res_q;
  logic             load;

  assign load   = advance_i && res_i.valid;
  assign free_o = !valid_q || m_tready_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && m_tready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {7'd0, res_q.found, res_q.field_length, res_q.field_byte};
  assign m_tuser_o  = res_q.kind;

endmodule

@@ dv/tb_gnss_response_field_extractor.sv @@
// Self-checking testbench for the GNSS response field extractor.
`timescale 1ns / 1ps

module tb_gnss_response_field_extractor;

  localparam int unsigned DrainCycles = 6;
  localparam logic [8*gre_pkg::PrefixLen-1:0] PrefixText = "+CGNSINF: ";
  localparam logic [7:0] CharLf = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
  } resp_char_t;

  typedef struct packed {
    gre_pkg::kind_e kind;
    logic [7:0]     fbyte;
    logic [7:0]     flen;
    logic           found;
  } extract_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [7:0]        s_axis_tdata_i = 8'h00;   // [7:0] rx_byte
  logic              s_axis_tlast_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [23:0]       m_axis_tdata_o;   // [7:0] field_byte, [15:8] field_length, [16] found
  logic              m_axis_tuser_o;   // [0] kind
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  gre_pkg::cfg_reg_e cfg_index_i = gre_pkg::CFG_FIELD_INDEX;
  logic [7:0]        cfg_data_i = 8'h00;

  resp_char_t queued_chars[$];
  extract_t   expected_extracts[$];
  extract_t   want_res;
  int         chars_pushed = 0;
  int         err_cnt = 0;
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  logic       in_fire = 1'b0;

  // Shadow of the parser and its registers.
  gre_pkg::phase_e ex_phase = gre_pkg::PH_SEEK;
  logic [3:0]      ex_matched = '0;
  logic [7:0]      ex_commas = '0;
  logic [7:0]      ex_taken = '0;
  logic [7:0]      cfg_field_idx = gre_pkg::FieldIdxReset;
  logic [7:0]      cfg_max_len = gre_pkg::MaxLenReset;

  gnss_response_field_extractor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] prefix_byte(input int unsigned i);
    return PrefixText[8*(gre_pkg::PrefixLen-1-i) +: 8];
  endfunction

  // Advances the shadow parser by one response byte and queues the result it causes.
  function automatic void extract_step(input logic [7:0] c, input logic eor);
    extract_t   res;
    logic       got;
    logic       take;
    logic [3:0] m;
    res  = '0;
    got  = 1'b0;
    take = 1'b0;
    case (ex_phase)
      gre_pkg::PH_SEEK: begin
        m = ex_matched;
        if (m < gre_pkg::PrefixLen && c == prefix_byte(m)) m = m + 4'd1;
        else m = (c == gre_pkg::CharPlus) ? 4'd1 : 4'd0;
        if (m >= gre_pkg::PrefixLen) begin
          m = '0;
          ex_commas = '0;
          ex_taken = '0;
          ex_phase = (cfg_field_idx == 8'd0) ? gre_pkg::PH_FIELD : gre_pkg::PH_SKIP;
        end
        ex_matched = m;
      end
      gre_pkg::PH_SKIP: begin
        if (c == gre_pkg::CharComma) begin
          if (ex_commas != gre_pkg::CntMax) ex_commas = ex_commas + 8'd1;
          if (ex_commas >= cfg_field_idx) ex_phase = gre_pkg::PH_FIELD;
        end
      end
      gre_pkg::PH_FIELD: begin
        if (c == gre_pkg::CharComma || c == gre_pkg::CharCr) begin
          res = '{kind: gre_pkg::KIND_DONE, fbyte: 8'h00, flen: ex_taken, found: 1'b1};
          got = 1'b1;
          ex_phase = gre_pkg::PH_DONE;
        end else if (ex_taken < cfg_max_len) begin
          take = 1'b1;
        end
      end
      default: ;
    endcase

    if (eor) begin
      // A response that ends before its field was closed reports not found.
      if (!got && ex_phase != gre_pkg::PH_DONE) begin
        res = '{kind: gre_pkg::KIND_DONE, fbyte: 8'h00, flen: 8'h00, found: 1'b0};
        got = 1'b1;
      end
      ex_phase = gre_pkg::PH_SEEK;
      ex_matched = '0;
      ex_commas = '0;
      ex_taken = '0;
    end else if (take) begin
      res = '{kind: gre_pkg::KIND_DATA, fbyte: c, flen: 8'h00, found: 1'b0};
      got = 1'b1;
      if (ex_taken != gre_pkg::CntMax) ex_taken = ex_taken + 8'd1;
    end
    if (got) expected_extracts.push_back(res);
  endfunction

  task automatic push_char(input logic [7:0] c, input logic eor);
    queued_chars.push_back('{c, eor});
    chars_pushed++;
  endtask

  function automatic logic [7:0] field_char();
    if ($urandom_range(99) < 85) return 8'($urandom_range(8'h2E, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  // Queues one response. A full response has a clean prefix, exactly max_fields
  // commas, so that field max_fields is the last one, and closes that field with CR.
  task automatic add_response(input int max_fields, input int max_flen, input bit full);
    logic [7:0] text[$];
    int         nf;
    int         fl;
    int         k;
    int         bad;
    int         r;
    if (!full && $urandom_range(99) < 25) begin
      if ($urandom_range(1)) text.push_back(8'($urandom_range(0, 255)));
      k = $urandom_range(1, gre_pkg::PrefixLen - 1);
      for (int i = 0; i < k; i++) text.push_back(prefix_byte(i));
      text.push_back(8'($urandom_range(0, 255)));
    end
    if (full || $urandom_range(99) < 88) begin
      bad = (!full && $urandom_range(99) < 10) ? $urandom_range(0, gre_pkg::PrefixLen - 1) : -1;
      for (int i = 0; i < gre_pkg::PrefixLen; i++)
        text.push_back((i == bad) ? 8'($urandom_range(0, 255)) : prefix_byte(i));
    end
    nf = full ? max_fields + 1 : $urandom_range(1, max_fields + 1);
    for (int j = 0; j < nf; j++) begin
      if (j != 0) text.push_back(gre_pkg::CharComma);
      fl = (full && j < nf - 1) ? 0 : $urandom_range(0, max_flen);
      repeat (fl) text.push_back(field_char());
    end
    r = full ? 60 : $urandom_range(99);
    if (r < 55) begin
      text.push_back(gre_pkg::CharCr);
      text.push_back(CharLf);
    end else if (r < 70) begin
      text.push_back(gre_pkg::CharCr);
    end else if (r >= 85) begin
      text.push_back(gre_pkg::CharComma);
    end
    if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < text.size(); i++) push_char(text[i], i == text.size() - 1);
  endtask

  task automatic write_reg(input gre_pkg::cfg_reg_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued byte is taken and every result is back, then lets
  // the pipeline settle for bytes that cause no result.
  task automatic wait_idle();
    wait (queued_chars.size() == 0 && !s_axis_tvalid_i);
    wait (expected_extracts.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input int max_fields, input int max_flen);
    int target;
    target = chars_pushed + n;
    while (chars_pushed < target) add_response(max_fields, max_flen, 1'b0);
    wait_idle();
  endtask

  // Byte driver: holds a beat until it is taken, otherwise offers the next one.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (in_fire) void'(queued_chars.pop_front());
      if (s_axis_tvalid_i && !in_fire) begin
        // Beat still waiting for tready.
      end else if (queued_chars.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= queued_chars[0].ch;
        s_axis_tlast_i  <= queued_chars[0].eor;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    in_fire <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == gre_pkg::CFG_FIELD_INDEX) cfg_field_idx = cfg_data_i;
        else cfg_max_len = cfg_data_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) extract_step(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_extracts.size() == 0) begin
          $error("result beat with nothing expected: tuser %0h tdata %06h",
                 m_axis_tuser_o, m_axis_tdata_o);
          err_cnt++;
        end else begin
          want_res = expected_extracts.pop_front();
          if (m_axis_tuser_o !== want_res.kind) begin
            $error("kind: expected %0d, actual %0d", want_res.kind, m_axis_tuser_o);
            err_cnt++;
          end
          if (m_axis_tdata_o[7:0] !== want_res.fbyte) begin
            $error("field_byte: expected %02h, actual %02h", want_res.fbyte,
                   m_axis_tdata_o[7:0]);
            err_cnt++;
          end
          if (m_axis_tdata_o[15:8] !== want_res.flen) begin
            $error("field_length: expected %0d, actual %0d", want_res.flen,
                   m_axis_tdata_o[15:8]);
            err_cnt++;
          end
          if (m_axis_tdata_o[16] !== want_res.found) begin
            $error("found: expected %0d, actual %0d", want_res.found, m_axis_tdata_o[16]);
            err_cnt++;
          end
          if (m_axis_tdata_o[23:17] !== 7'd0) begin
            $error("tdata padding: expected 0, actual %02h", m_axis_tdata_o[23:17]);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a false start on '+', the field right after the prefix,
    // extreme byte values, a comma terminator and a byte after the done.
    push_char(gre_pkg::CharPlus, 1'b0);
    push_char("C", 1'b0);
    for (int i = 0; i < gre_pkg::PrefixLen; i++) push_char(prefix_byte(i), 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(gre_pkg::CharComma, 1'b0);
    push_char("Z", 1'b1);
    wait_idle();

    // Shrink the length limit, stop in the middle of the comma skip, then retarget the
    // field index and widen the length limit while the response is still open.
    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'd2);
    write_reg(gre_pkg::CFG_MAX_LEN, 8'd1);
    for (int i = 0; i < gre_pkg::PrefixLen; i++) push_char(prefix_byte(i), 1'b0);
    push_char(gre_pkg::CharComma, 1'b0);
    wait_idle();
    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'd1);
    push_char(gre_pkg::CharComma, 1'b0);
    push_char("A", 1'b0);
    push_char("B", 1'b0);
    wait_idle();
    write_reg(gre_pkg::CFG_MAX_LEN, 8'd3);
    push_char("C", 1'b0);
    push_char("D", 1'b0);
    push_char("E", 1'b0);
    push_char(gre_pkg::CharCr, 1'b1);
    wait_idle();

    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'd0);
    write_reg(gre_pkg::CFG_MAX_LEN, 8'd255);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    run_random(40, 3, 12);

    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'd1);
    write_reg(gre_pkg::CFG_MAX_LEN, 8'd0);
    src_idle_pct = 62;
    snk_stall_pct = 0;
    run_random(40, 4, 6);

    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'($urandom_range(2, 6)));
    write_reg(gre_pkg::CFG_MAX_LEN, 8'($urandom_range(1, 8)));
    src_idle_pct = 0;
    snk_stall_pct = 62;
    run_random(40, 8, 10);

    // Highest field index: only a response with 255 commas reaches the field.
    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'd255);
    write_reg(gre_pkg::CFG_MAX_LEN, 8'd255);
    src_idle_pct = 35;
    snk_stall_pct = 35;
    add_response(255, 6, 1'b1);
    run_random(20, 5, 4);

    write_reg(gre_pkg::CFG_FIELD_INDEX, 8'($urandom_range(0, 4)));
    write_reg(gre_pkg::CFG_MAX_LEN, 8'($urandom_range(0, 20)));
    run_random(40, 4, 16);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/gre_pkg.sv
sv/gre_in_reg.sv
sv/gre_core.sv
sv/gre_out_reg.sv
sv/gnss_response_field_extractor.sv
dv/tb_gnss_response_field_extractor.sv
